FILE: hdl/trr_pkg.sv
// shared types, sizes and helper functions for the two-list round-robin scheduler
`timescale 1ns / 1ps

package trr_pkg;

    // number of task slots and derived widths
    localparam int NUM_TASKS = 16;
    localparam int IDX_W     = $clog2(NUM_TASKS);
    localparam int CNT_W     = $clog2(NUM_TASKS + 1);
    localparam int TID_W     = 4;
    localparam int PRI_W     = 8;

    // command codes
    typedef enum logic [1:0] {
        OP_YIELD = 2'd0,
        OP_ADD   = 2'd1,
        OP_SET   = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    // input beat
    typedef struct packed {
        t_opcode            opcode;
        logic [TID_W-1:0]   task_id;
        logic [PRI_W-1:0]   priority_req;
        logic               runnable;
    } t_cmd;

    // result beat
    typedef struct packed {
        logic [TID_W-1:0]   run_task;
        logic               no_runnable;
    } t_result;

    // write request into the task table
    typedef struct packed {
        logic               add;
        logic               set;
        logic [IDX_W-1:0]   id;
        logic [PRI_W-1:0]   prio;
        logic               run;
    } t_tbl_wr;

    // task id addresses an existing slot
    function automatic logic id_in_range(input logic [TID_W-1:0] id);
        return int'(id) < NUM_TASKS;
    endfunction

    // task id to table index
    function automatic logic [IDX_W-1:0] to_idx(input logic [TID_W-1:0] id);
        return IDX_W'(id);
    endfunction

    // circular list pointer advance
    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(NUM_TASKS - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

FILE: hdl/trr_ram.sv
// generic single-write, single-read memory with registered read data
`timescale 1ns / 1ps

module trr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/trr_task_table.sv
// per-task priority memory and runnable flags
`timescale 1ns / 1ps

module trr_task_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  trr_pkg::t_tbl_wr           i_wr,
    input  logic [trr_pkg::IDX_W-1:0]  i_run_addr,
    output logic                       o_run,
    input  logic                       i_prio_re,
    input  logic [trr_pkg::IDX_W-1:0]  i_prio_addr,
    output logic [trr_pkg::PRI_W-1:0]  o_prio
);

    logic [trr_pkg::PRI_W-1:0] r_prio_mem [trr_pkg::NUM_TASKS];
    logic [trr_pkg::NUM_TASKS-1:0] r_prio_valid;
    logic [trr_pkg::NUM_TASKS-1:0] r_run;
    logic [trr_pkg::PRI_W-1:0] r_prio_q;
    logic                      r_prio_valid_q;

    // flags and valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= '0;
            r_prio_valid <= '0;
        end else begin
            if (i_wr.add || i_wr.set) begin
                r_run[i_wr.id] <= i_wr.run;
            end
            if (i_wr.add) begin
                r_prio_valid[i_wr.id] <= 1'b1;
            end
        end
    end

    // priority memory write
    always_ff @(posedge i_clk) begin
        if (i_wr.add) begin
            r_prio_mem[i_wr.id] <= i_wr.prio;
        end
    end

    // priority read, registered; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (i_prio_re) begin
            r_prio_q       <= r_prio_mem[i_prio_addr];
            r_prio_valid_q <= r_prio_valid[i_prio_addr];
        end
    end

    assign o_prio = r_prio_valid_q ? r_prio_q : '0;
    assign o_run  = r_run[i_run_addr];

endmodule

FILE: hdl/two_list_round_robin_scheduler.sv
// top level: command decode, list pointers and the yield scan sequencer
`timescale 1ns / 1ps

// Two-list round-robin scheduler. A command beat is taken when start is high
// and busy is low. Add and set-runnable give no result. A yield gives
// exactly one result beat, shown for one cycle with o_strobe; the receiver
// cannot hold it off and must take it then. A yield that keeps the current
// task has its result registered straight from the check state. Otherwise
// the scan walks the active list one entry at a time: each head is read from
// the list memory through its registered output before its runnable flag is
// tested, and the lists swap roles when the active list runs dry. Busy falls
// in the cycle the result is shown.
module two_list_round_robin_scheduler (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  trr_pkg::t_cmd    i_cmd,
    output logic             o_strobe,
    output trr_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_PEEK,
        S_PRIO
    } t_state;

    t_state r_state;
    logic   r_pass;
    logic   r_active;

    // pointers of the active and inactive lists
    logic [trr_pkg::IDX_W-1:0] r_act_head, r_act_tail, r_ina_head, r_ina_tail;
    logic [trr_pkg::CNT_W-1:0] r_act_cnt, r_ina_cnt;

    logic [trr_pkg::TID_W-1:0] r_cur;
    logic                      r_cur_valid;
    logic [trr_pkg::PRI_W-1:0] r_slices;
    logic [trr_pkg::TID_W-1:0] r_h;
    logic                      r_strobe;
    trr_pkg::t_result          r_res;

    logic                      accept;
    logic                      id_ok;
    logic                      act_full, ina_full;
    logic                      keep;
    logic                      push_act, push_ina;
    logic [trr_pkg::TID_W-1:0] ina_data;
    logic [trr_pkg::TID_W-1:0] head_q;
    logic [trr_pkg::TID_W-1:0] rdata_a, rdata_b;
    logic                      we_a, we_b;
    logic [trr_pkg::TID_W-1:0] wdata;
    logic [trr_pkg::IDX_W-1:0] waddr;
    logic                      rd_head;
    logic                      run_flag;
    logic [trr_pkg::IDX_W-1:0] run_addr;
    logic [trr_pkg::PRI_W-1:0] prio;
    trr_pkg::t_tbl_wr          tbl_wr;

    // handshake and command decode
    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign id_ok    = trr_pkg::id_in_range(i_cmd.task_id);
    assign act_full = (r_act_cnt == trr_pkg::CNT_W'(trr_pkg::NUM_TASKS));
    assign ina_full = (r_ina_cnt == trr_pkg::CNT_W'(trr_pkg::NUM_TASKS));

    // head of the active list, from whichever memory holds it
    assign head_q   = r_active ? rdata_b : rdata_a;

    // runnable lookup address: current task on check, scanned head on peek
    assign run_addr = (r_state == S_PEEK) ? trr_pkg::to_idx(head_q)
                                          : trr_pkg::to_idx(r_cur);
    assign keep     = r_cur_valid && (r_slices != '0) && run_flag;

    // list appends
    assign push_act = accept && (i_cmd.opcode == trr_pkg::OP_ADD) && id_ok && !act_full;
    assign push_ina = !ina_full &&
                      (((r_state == S_CHECK) && !keep && r_cur_valid) ||
                       ((r_state == S_PEEK) && !run_flag));
    assign ina_data = (r_state == S_CHECK) ? r_cur : head_q;

    // list memory port steering
    assign we_a    = (push_act && !r_active) || (push_ina && r_active);
    assign we_b    = (push_act && r_active) || (push_ina && !r_active);
    assign wdata   = push_act ? i_cmd.task_id : ina_data;
    assign waddr   = push_act ? r_act_tail : r_ina_tail;
    assign rd_head = (r_state == S_SCAN) && (r_act_cnt != '0);

    // task table writes
    assign tbl_wr.add  = accept && (i_cmd.opcode == trr_pkg::OP_ADD) && id_ok;
    assign tbl_wr.set  = accept && (i_cmd.opcode == trr_pkg::OP_SET) && id_ok;
    assign tbl_wr.id   = trr_pkg::to_idx(i_cmd.task_id);
    assign tbl_wr.prio = i_cmd.priority_req;
    assign tbl_wr.run  = i_cmd.runnable;

    trr_ram #(
        .WIDTH (trr_pkg::TID_W),
        .DEPTH (trr_pkg::NUM_TASKS)
    ) u_list_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_head && !r_active),
        .i_raddr (r_act_head),
        .o_rdata (rdata_a)
    );

    trr_ram #(
        .WIDTH (trr_pkg::TID_W),
        .DEPTH (trr_pkg::NUM_TASKS)
    ) u_list_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_head && r_active),
        .i_raddr (r_act_head),
        .o_rdata (rdata_b)
    );

    trr_task_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (tbl_wr),
        .i_run_addr  (run_addr),
        .o_run       (run_flag),
        .i_prio_re   (r_state == S_PEEK),
        .i_prio_addr (trr_pkg::to_idx(head_q)),
        .o_prio      (prio)
    );

    // sequencer, list pointers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= 1'b0;
            r_active    <= 1'b0;
            r_act_head  <= '0;
            r_act_tail  <= '0;
            r_act_cnt   <= '0;
            r_ina_head  <= '0;
            r_ina_tail  <= '0;
            r_ina_cnt   <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_slices    <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (push_act) begin
                        r_act_tail <= trr_pkg::ptr_inc(r_act_tail);
                        r_act_cnt  <= r_act_cnt + 1'b1;
                    end
                    if (accept && (i_cmd.opcode == trr_pkg::OP_YIELD)) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (keep) begin
                        r_slices       <= r_slices - 1'b1;
                        r_res.run_task <= r_cur;
                        r_res.no_runnable <= 1'b0;
                        r_strobe       <= 1'b1;
                        r_state        <= S_IDLE;
                    end else begin
                        if (push_ina) begin
                            r_ina_tail <= trr_pkg::ptr_inc(r_ina_tail);
                            r_ina_cnt  <= r_ina_cnt + 1'b1;
                        end
                        r_cur_valid <= 1'b0;
                        r_cur       <= '0;
                        r_pass      <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_act_cnt != '0) begin
                        r_state <= S_PEEK;
                    end else if (!r_pass) begin
                        // active list ran dry: swap roles and scan once more
                        r_act_head <= r_ina_head;
                        r_act_tail <= r_ina_tail;
                        r_act_cnt  <= r_ina_cnt;
                        r_ina_head <= r_act_head;
                        r_ina_tail <= r_act_tail;
                        r_ina_cnt  <= r_act_cnt;
                        r_active   <= !r_active;
                        r_pass     <= 1'b1;
                    end else begin
                        r_slices          <= '0;
                        r_res.run_task    <= '0;
                        r_res.no_runnable <= 1'b1;
                        r_strobe          <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                S_PEEK: begin
                    r_h <= head_q;
                    if (run_flag) begin
                        r_state <= S_PRIO;
                    end else begin
                        // blocked head moves to the inactive list
                        r_act_head <= trr_pkg::ptr_inc(r_act_head);
                        r_act_cnt  <= r_act_cnt - 1'b1;
                        if (push_ina) begin
                            r_ina_tail <= trr_pkg::ptr_inc(r_ina_tail);
                            r_ina_cnt  <= r_ina_cnt + 1'b1;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_PRIO: begin
                    r_act_head        <= trr_pkg::ptr_inc(r_act_head);
                    r_act_cnt         <= r_act_cnt - 1'b1;
                    r_cur             <= r_h;
                    r_cur_valid       <= 1'b1;
                    r_slices          <= (prio == '0) ? '0 : prio - 1'b1;
                    r_res.run_task    <= r_h;
                    r_res.no_runnable <= 1'b0;
                    r_strobe          <= 1'b1;
                    r_state           <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // result beats are never back to back
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe in two consecutive cycles");

    // list fill counts stay within capacity
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act_cnt <= trr_pkg::CNT_W'(trr_pkg::NUM_TASKS)) &&
        (r_ina_cnt <= trr_pkg::CNT_W'(trr_pkg::NUM_TASKS)))
        else $error("list count beyond capacity");

    // an accepted yield starts the check of the current task
    a_yield_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.opcode == trr_pkg::OP_YIELD)) |=> (r_state == S_CHECK))
        else $error("yield did not enter check");

    // a failed search leaves no current task and a zero task id
    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.no_runnable) |->
            ((o_result.run_task == '0) && !r_cur_valid && (r_slices == '0)))
        else $error("no-runnable result with stale task state");

endmodule
